### rtl/core/fwdbv_pkg.sv
// ----------------------------------------------------------------------------
// fwdbv_pkg
// Shared widths, command and status codes, and the control word that the
// queue controller broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package fwdbv_pkg;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned ST_W   = 3;
  localparam int unsigned FILL_W = 5;

  localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEL = 2'd2;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_ZERO     = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctl_t;

endpackage

### rtl/core/fwdbv_cell.sv
// ----------------------------------------------------------------------------
// fwdbv_cell
// One queue slot. It loads the broadcast word on an enqueue aimed at its
// position, takes its neighbor's word on a dequeue, and takes part in the
// delete wave that walks from the head one cell per cycle.
// ----------------------------------------------------------------------------
module fwdbv_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fwdbv_pkg::cell_ctl_t        ctl,
  input  logic [fwdbv_pkg::VAL_W-1:0] value,
  input  logic [CW-1:0]               count,
  input  logic                        tok_in,
  input  logic                        hit_in,
  input  logic [fwdbv_pkg::VAL_W-1:0] nxt_slot,
  output logic                        tok_out,
  output logic                        hit_out,
  output logic                        hit_now,
  output logic [fwdbv_pkg::VAL_W-1:0] slot
);

  localparam logic [CW-1:0] MY_IDX   = CW'(IDX);
  localparam logic [CW-1:0] NEXT_IDX = CW'(IDX + 1);

  logic [fwdbv_pkg::VAL_W-1:0] slot_r, slot_nxt;
  logic                        tok_r, tok_nxt;
  logic                        hit_r, hit_nxt;
  logic                        eq;
  logic                        take;

  always_comb begin
    eq       = (slot_r == value);
    hit_now  = tok_in & (hit_in | eq);
    take     = ctl.deq | hit_now;
    slot_nxt = slot_r;
    if (ctl.enq && (count == MY_IDX)) begin
      slot_nxt = value;
    end else if (take) begin
      slot_nxt = nxt_slot;
    end
    tok_nxt = tok_in & (NEXT_IDX < count);
    hit_nxt = hit_in | eq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
      hit_r <= hit_nxt;
    end
    slot_r <= slot_nxt;
  end

  assign tok_out = tok_r;
  assign hit_out = hit_r;
  assign slot    = slot_r;

endmodule

### rtl/core/fifo_with_delete_by_value.sv
// ----------------------------------------------------------------------------
// fifo_with_delete_by_value
// Bounded queue of nonzero 32-bit words with enqueue, dequeue and delete of
// the first matching word, built as a row of storage cells.
// ----------------------------------------------------------------------------
// A command word enters on the in_ channel (in_cmd, in_value) and gives exactly
// one result word on the out_ channel: a status, the dequeued value (zero
// otherwise) and the fill count after the command.
// Enqueue and dequeue write the result register from the execute state once it
// is free and return to idle with it, so the next command can then be taken.
// A delete sends a token down the cell row from the head, one cell per cycle;
// at the matching cell and behind it each cell takes its neighbor's word, which
// closes the gap in order; the result is given once the token has left the row.
// One command is in work at a time; in_ready is high whenever the controller
// is idle, so the next command is taken while a result still waits.
// When the receiver holds out_ready low, the result register holds its word
// and the controller waits with the next result until the register is free.
// Reset empties the queue and drops any pending result; slot contents are not
// cleared, only the fill count.
// ----------------------------------------------------------------------------
module fifo_with_delete_by_value #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fwdbv_pkg::CMD_W-1:0]   in_cmd,
  input  logic [fwdbv_pkg::VAL_W-1:0]   in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fwdbv_pkg::ST_W-1:0]    out_status,
  output logic [fwdbv_pkg::VAL_W-1:0]   out_value_out,
  output logic [fwdbv_pkg::FILL_W-1:0]  out_fill_count
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DEL,
    S_FIN
  } state_t;

  state_t                              state_r, state_nxt;
  logic [fwdbv_pkg::CMD_W-1:0]         cmd_r, cmd_nxt;
  logic [fwdbv_pkg::VAL_W-1:0]         val_r, val_nxt;
  logic [CW-1:0]                       count_r, count_nxt;
  logic                                start_r, start_nxt;
  logic                                found_r, found_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [fwdbv_pkg::ST_W-1:0]          out_status_r, out_status_nxt;
  logic [fwdbv_pkg::VAL_W-1:0]         out_value_r, out_value_nxt;
  logic [fwdbv_pkg::FILL_W-1:0]        out_fill_r, out_fill_nxt;

  fwdbv_pkg::cell_ctl_t                ctl;
  logic [DEPTH:0]                      tok_link;
  logic [DEPTH:0]                      hit_link;
  logic [DEPTH-1:0]                    hit_now;
  logic [fwdbv_pkg::VAL_W-1:0]         slot [DEPTH];
  logic                                out_free;
  logic                                tok_any;

  assign tok_link[0] = start_r;
  assign hit_link[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [fwdbv_pkg::VAL_W-1:0] nxt_src;
    if (i < DEPTH - 1) begin : g_mid
      assign nxt_src = slot[i+1];
    end else begin : g_tail
      assign nxt_src = slot[i];
    end
    fwdbv_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .value    (val_r),
      .count    (count_r),
      .tok_in   (tok_link[i]),
      .hit_in   (hit_link[i]),
      .nxt_slot (nxt_src),
      .tok_out  (tok_link[i+1]),
      .hit_out  (hit_link[i+1]),
      .hit_now  (hit_now[i]),
      .slot     (slot[i])
    );
  end

  assign out_free = !out_valid_r || out_ready;
  assign tok_any  = |tok_link;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    val_nxt        = val_r;
    count_nxt      = count_r;
    start_nxt      = 1'b0;
    found_nxt      = found_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_fill_nxt   = out_fill_r;
    ctl            = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          val_nxt   = in_value;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_r == fwdbv_pkg::CMD_DEL) begin
          found_nxt = 1'b0;
          start_nxt = (count_r != '0);
          state_nxt = S_DEL;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = fwdbv_pkg::ST_OK;
          out_value_nxt  = '0;
          case (cmd_r)
            fwdbv_pkg::CMD_ENQ: begin
              if (val_r == '0) begin
                out_status_nxt = fwdbv_pkg::ST_ZERO;
              end else if (count_r == FULL_CNT) begin
                out_status_nxt = fwdbv_pkg::ST_FULL;
              end else begin
                ctl.enq   = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            fwdbv_pkg::CMD_DEQ: begin
              if (count_r == '0) begin
                out_status_nxt = fwdbv_pkg::ST_EMPTY;
              end else begin
                ctl.deq       = 1'b1;
                out_value_nxt = slot[0];
                count_nxt     = count_r - 1'b1;
              end
            end
            default: begin
            end
          endcase
          out_fill_nxt = fwdbv_pkg::FILL_W'(count_nxt);
          state_nxt    = S_IDLE;
        end
      end
      S_DEL: begin
        found_nxt = found_r | (|hit_now);
        if (!tok_any) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          if (found_r) begin
            out_status_nxt = fwdbv_pkg::ST_OK;
            count_nxt      = count_r - 1'b1;
          end else begin
            out_status_nxt = fwdbv_pkg::ST_NOTFOUND;
          end
          out_fill_nxt = fwdbv_pkg::FILL_W'(count_nxt);
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      start_r     <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      start_r     <= start_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    val_r        <= val_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_value_out  = out_value_r;
  assign out_fill_count = out_fill_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("fill count above queue depth");

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_link))
    else $error("more than one delete token in the cell row");

  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.enq |=> (count_r == $past(count_r) + 1'b1) && out_valid)
    else $error("enqueue did not advance the fill count");

  a_token_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !tok_any)
    else $error("delete token alive while the controller is idle");
`endif

endmodule
